// File: rtl/fdns_pkg.sv
package fdns_pkg;

  // Directory layout: a count header, then fixed-size entries whose
  // header holds size, key and two reserved bytes ahead of the name.
  localparam int COUNT_BYTES  = 4;
  localparam int HEADER_BYTES = 8;
  localparam int SIZE_END     = 4;
  localparam int KEY_END      = 6;

  // Target name storage: seven 64-bit configuration words.
  localparam int NAME_WORDS = 7;
  localparam int NAME_MAX   = NAME_WORDS * 8;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_WORD_0 = 3'd1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_COUNT = 3'b010,
    PH_ENTRY = 3'b100
  } fdns_phase_t;

  typedef struct packed {
    logic [LEN_W-1:0]              name_length;
    logic [NAME_MAX-1:0][7:0]      name_bytes;
  } fdns_cfg_t;

  typedef struct packed {
    logic        found;
    logic [15:0] entry_key;
    logic [31:0] entry_size;
  } fdns_result_t;

endpackage

// File: rtl/fdns_core.sv
module fdns_core #(
  parameter int NAME_BYTES = 56
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 first,
  input  logic [7:0]           data_byte,
  input  fdns_pkg::fdns_cfg_t  cfg,
  output logic                 emit,
  output fdns_pkg::fdns_result_t result
);

  localparam int ENTRY_BYTES = fdns_pkg::HEADER_BYTES + NAME_BYTES;
  localparam int POS_W       = $clog2(ENTRY_BYTES);

  fdns_pkg::fdns_phase_t phase, phase_next, phase_eff;
  logic [POS_W-1:0] pos, pos_next, pos_start, name_pos;
  logic [31:0]      entries_left, entries_left_next, count_shift, left_dec;
  logic [31:0]      size_acc, size_acc_next;
  logic [15:0]      key_acc, key_acc_next;
  logic             matching, matching_next, matching_now, byte_ok;
  logic [fdns_pkg::LEN_W-1:0] n;
  logic [7:0]       tgt_byte;

  always_comb begin
    phase_eff   = first ? fdns_pkg::PH_COUNT : phase;
    pos_start   = first ? '0 : pos;
    count_shift = {(first ? 24'd0 : entries_left[23:0]), data_byte};
    left_dec    = entries_left - 32'd1;

    // Position within the name field, valid once past the entry header.
    name_pos = pos - POS_W'(fdns_pkg::HEADER_BYTES);
    n        = fdns_pkg::LEN_W'(name_pos);
    tgt_byte = cfg.name_bytes[n];

    if (pos < POS_W'(fdns_pkg::HEADER_BYTES)) begin
      byte_ok = 1'b1;
    end else if (n < cfg.name_length) begin
      byte_ok = (data_byte == tgt_byte);
    end else if (n == cfg.name_length) begin
      byte_ok = (data_byte == 8'd0);
    end else begin
      byte_ok = 1'b1;
    end
    matching_now = matching && byte_ok;

    phase_next        = phase_eff;
    pos_next          = pos_start;
    entries_left_next = entries_left;
    size_acc_next     = size_acc;
    key_acc_next      = key_acc;
    matching_next     = matching;
    emit              = 1'b0;
    result            = '0;

    unique case (phase_eff)
      fdns_pkg::PH_IDLE: begin
        phase_next = fdns_pkg::PH_IDLE;
      end
      fdns_pkg::PH_COUNT: begin
        entries_left_next = count_shift;
        if (pos_start != POS_W'(fdns_pkg::COUNT_BYTES - 1)) begin
          pos_next = pos_start + POS_W'(1);
        end else if (count_shift == 32'd0) begin
          emit       = 1'b1;
          phase_next = fdns_pkg::PH_IDLE;
          pos_next   = '0;
        end else begin
          phase_next    = fdns_pkg::PH_ENTRY;
          pos_next      = '0;
          size_acc_next = '0;
          key_acc_next  = '0;
          matching_next = 1'b1;
        end
      end
      fdns_pkg::PH_ENTRY: begin
        if (pos < POS_W'(fdns_pkg::SIZE_END)) begin
          size_acc_next = {size_acc[23:0], data_byte};
        end else if (pos < POS_W'(fdns_pkg::KEY_END)) begin
          key_acc_next = {key_acc[7:0], data_byte};
        end
        if (pos != POS_W'(ENTRY_BYTES - 1)) begin
          pos_next      = pos + POS_W'(1);
          matching_next = matching_now;
        end else if (matching_now &&
                     ({1'b0, cfg.name_length} < 7'(NAME_BYTES))) begin
          emit              = 1'b1;
          result.found      = 1'b1;
          result.entry_key  = key_acc;
          result.entry_size = size_acc;
          phase_next        = fdns_pkg::PH_IDLE;
          pos_next          = '0;
        end else if (left_dec == 32'd0) begin
          emit              = 1'b1;
          entries_left_next = left_dec;
          phase_next        = fdns_pkg::PH_IDLE;
          pos_next          = '0;
        end else begin
          entries_left_next = left_dec;
          pos_next          = '0;
          size_acc_next     = '0;
          key_acc_next      = '0;
          matching_next     = 1'b1;
        end
      end
      default: begin
        phase_next = fdns_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= fdns_pkg::PH_IDLE;
      pos          <= '0;
      entries_left <= '0;
      size_acc     <= '0;
      key_acc      <= '0;
      matching     <= 1'b1;
    end else if (step) begin
      phase        <= phase_next;
      pos          <= pos_next;
      entries_left <= entries_left_next;
      size_acc     <= size_acc_next;
      key_acc      <= key_acc_next;
      matching     <= matching_next;
    end
  end

endmodule

// File: rtl/file_directory_name_search.sv
// Path: an accepted item sits in the input register until it passes the parser, and the result
// register loads when the item that closes a directory passes, from where the result is taken.
// Throughput: one item per cycle; the parser advances one byte per accepted item.
// Only an item that produces a result waits while an earlier result is still stalled;
// every other item passes the parser and the input side keeps taking items.
// Reset (rst, synchronous, active high) clears the parser, both valids and the target name.
module file_directory_name_search #(
  parameter int NAME_BYTES = 56
) (
  input  logic        clk,
  input  logic        rst,

  // Input stream: one directory byte per item.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first

  // Result stream: at most one item per directory.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] entry_key, [47:16] entry_size
  output logic        m_tuser,   // [0] found

  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [fdns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdns_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Target name and length. The user writes only while the block is idle (unenforced).
  fdns_pkg::fdns_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      if (cfg_index == fdns_pkg::REG_NAME_LENGTH) begin
        cfg.name_length <= cfg_data[fdns_pkg::LEN_W-1:0];
      end
      for (int w = 0; w < fdns_pkg::NAME_WORDS; w++) begin
        if (cfg_index == fdns_pkg::REG_NAME_WORD_0 + fdns_pkg::CFG_IDX_W'(w)) begin
          cfg.name_bytes[8*w +: 8] <= cfg_data;
        end
      end
    end
  end

  // Input register. The held item is handed to the parser unless it produces
  // a result while the result register is still holding an earlier one.
  logic       in_valid;
  logic       in_first;
  logic [7:0] in_byte;
  logic       fire;

  // Parser: all byte-level decoding and name comparison for one item.
  logic                   emit;
  fdns_pkg::fdns_result_t result;

  assign fire     = in_valid && (!emit || !m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_first <= s_tuser;
      in_byte  <= s_tdata;
    end
  end

  fdns_core #(
    .NAME_BYTES(NAME_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (fire),
    .first    (in_first),
    .data_byte(in_byte),
    .cfg      (cfg),
    .emit     (emit),
    .result   (result)
  );

  // Result register. A waiting result stays until it is taken, even while
  // items that produce nothing keep passing the parser.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      m_tuser <= result.found;
      m_tdata <= {result.entry_size, result.entry_key};
    end
  end

endmodule

// File: rtl/fdns_checker.sv
module fdns_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A miss carries zero key and size.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 48'd0)
    else $error("miss result with nonzero key or size");

  // Reset leaves the block empty and ready.
  a_reset: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("block not empty after reset");

  // A consumer that is taking results never stalls the input side.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is ready");

  // With no item taken and no result pending, no result appears afterwards.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!(s_tvalid && s_tready) && !m_tvalid) ##1 (!(s_tvalid && s_tready) && !m_tvalid)
    |=> !m_tvalid)
    else $error("result without a pending item");

endmodule

bind file_directory_name_search fdns_checker u_fdns_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

// File: dv/file_directory_name_search_tb.sv
module file_directory_name_search_tb;

  // The run is bounded by a cycle count far above the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;
  // A result leaves after its item passes the input and result registers; allow a margin.
  localparam int DRAIN_CYCLES = 8;
  localparam int ENTRY_LEN    = fdns_pkg::HEADER_BYTES + fdns_pkg::NAME_MAX;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASES       = 9;

  // How the name field of a generated entry relates to the current target.
  typedef enum {
    ENTRY_MATCH,     // target bytes followed by a zero byte
    ENTRY_BAD_BYTE,  // one target byte altered
    ENTRY_BAD_END,   // the byte after the target is not zero
    ENTRY_NOISE      // random name bytes
  } entry_kind_t;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } dir_byte_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata   = '0;   // [7:0] data_byte
  logic                            s_tuser   = 1'b0; // [0] first
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [47:0]                     m_tdata;          // [15:0] entry_key, [47:16] entry_size
  logic                            m_tuser;          // [0] found
  logic                            cfg_we    = 1'b0;
  logic [fdns_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fdns_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  file_directory_name_search dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Copy of the target name as the block should hold it after each write.
  logic [fdns_pkg::LEN_W-1:0] target_len = '0;
  logic [7:0]                 target_name [fdns_pkg::NAME_MAX];

  // Parser state of the directory search, tracked item by item.
  fdns_pkg::fdns_phase_t dir_state    = fdns_pkg::PH_IDLE;
  int unsigned           dir_pos      = 0;
  logic [31:0]           entries_left = '0;
  logic [31:0]           size_acc     = '0;
  logic [15:0]           key_acc      = '0;
  logic                  name_ok      = 1'b1;

  // Search results still owed by the block, oldest first.
  fdns_pkg::fdns_result_t results_due [$];
  // Directory bytes waiting to be sent.
  dir_byte_t              byte_queue [$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        in_taken      = 1'b0;
  int          mismatches    = 0;
  int unsigned cycles        = 0;
  int          gen_items     = 0;
  int          gen_dirs      = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Search prediction
  // ---------------------------------------------------------------------------

  // A result closes the directory: bytes are ignored until the next first flag.
  task automatic post_result(input logic hit);
    fdns_pkg::fdns_result_t r;
    r.found      = hit;
    r.entry_key  = hit ? key_acc : '0;
    r.entry_size = hit ? size_acc : '0;
    results_due.push_back(r);
    dir_state = fdns_pkg::PH_IDLE;
    dir_pos   = 0;
  endtask

  task automatic open_entry();
    dir_pos  = 0;
    size_acc = '0;
    key_acc  = '0;
    name_ok  = 1'b1;
  endtask

  task automatic search_byte(input logic first, input logic [7:0] b);
    int unsigned n;
    // A first flag restarts the parse at count byte 0, whatever was going on.
    if (first) begin
      dir_state    = fdns_pkg::PH_COUNT;
      dir_pos      = 0;
      entries_left = '0;
    end
    case (dir_state)
      fdns_pkg::PH_COUNT: begin
        entries_left = {entries_left[23:0], b};
        dir_pos++;
        if (dir_pos == fdns_pkg::COUNT_BYTES) begin
          if (entries_left == 0) begin
            post_result(1'b0);
          end else begin
            dir_state = fdns_pkg::PH_ENTRY;
            open_entry();
          end
        end
      end
      fdns_pkg::PH_ENTRY: begin
        if (dir_pos < fdns_pkg::SIZE_END) begin
          size_acc = {size_acc[23:0], b};
        end else if (dir_pos < fdns_pkg::KEY_END) begin
          key_acc = {key_acc[7:0], b};
        end else if (dir_pos >= fdns_pkg::HEADER_BYTES) begin
          // Name bytes: the target must match and be followed by a zero byte.
          n = dir_pos - fdns_pkg::HEADER_BYTES;
          if (n < target_len) begin
            if (b != target_name[n]) name_ok = 1'b0;
          end else if (n == target_len && b != 8'h00) begin
            name_ok = 1'b0;
          end
        end
        if (dir_pos + 1 < ENTRY_LEN) begin
          dir_pos++;
        end else begin
          // A target that fills the whole name leaves no room for the
          // terminating zero, so such an entry never matches.
          if (target_len >= fdns_pkg::NAME_MAX) name_ok = 1'b0;
          if (name_ok) begin
            post_result(1'b1);
          end else begin
            entries_left--;
            if (entries_left == 0) post_result(1'b0);
            else open_entry();
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Directory generation
  // ---------------------------------------------------------------------------

  // Appends one 64-byte entry built against the current target name.
  task automatic push_entry(input entry_kind_t kind);
    logic [7:0]  e [ENTRY_LEN];
    logic [31:0] sz;
    logic [15:0] k;
    int          len;
    int          j;
    sz  = $urandom;
    k   = 16'($urandom);
    len = target_len;
    for (j = 0; j < 4; j++) e[j] = sz[31-8*j -: 8];
    e[4] = k[15:8];
    e[5] = k[7:0];
    e[6] = 8'($urandom);
    e[7] = 8'($urandom);
    for (j = 0; j < fdns_pkg::NAME_MAX; j++) begin
      e[fdns_pkg::HEADER_BYTES+j] = (j < len) ? target_name[j] :
                                    (j == len) ? 8'h00 : 8'($urandom);
    end
    // With an empty target there is no target byte to alter.
    if (kind == ENTRY_BAD_BYTE && len == 0) kind = ENTRY_BAD_END;
    case (kind)
      ENTRY_BAD_BYTE: begin
        j = $urandom_range(0, ((len < fdns_pkg::NAME_MAX) ? len : fdns_pkg::NAME_MAX) - 1);
        e[fdns_pkg::HEADER_BYTES+j] ^= 8'($urandom_range(1, 255));
      end
      ENTRY_BAD_END: begin
        if (len < fdns_pkg::NAME_MAX) begin
          e[fdns_pkg::HEADER_BYTES+len] = 8'($urandom_range(1, 255));
        end
      end
      ENTRY_NOISE: begin
        for (j = 0; j < fdns_pkg::NAME_MAX; j++) begin
          e[fdns_pkg::HEADER_BYTES+j] = 8'($urandom);
        end
      end
      default: ;
    endcase
    for (j = 0; j < ENTRY_LEN; j++) byte_queue.push_back({1'b0, e[j]});
  endtask

  // Appends a directory: the count, then `sent` entries, the one at match_at
  // matching. A keep of zero or more truncates the directory to that many bytes.
  task automatic add_directory(input logic [31:0] count, input int sent,
                               input int match_at, input int keep);
    int start;
    int j;
    start = byte_queue.size();
    for (j = 0; j < fdns_pkg::COUNT_BYTES; j++) begin
      byte_queue.push_back({j == 0, count[31-8*j -: 8]});
    end
    for (j = 0; j < sent; j++) begin
      push_entry(j == match_at ? ENTRY_MATCH
                               : entry_kind_t'($urandom_range(ENTRY_BAD_BYTE, ENTRY_NOISE)));
    end
    if (keep >= 0) begin
      while (byte_queue.size() > start + keep) void'(byte_queue.pop_back());
    end else begin
      gen_dirs++;
    end
    gen_items += byte_queue.size() - start;
  endtask

  // Random bytes; first_pct of them carry the first flag.
  task automatic push_noise(input int n, input int first_pct);
    for (int j = 0; j < n; j++) begin
      byte_queue.push_back({$urandom_range(0, 99) < first_pct, 8'($urandom)});
    end
  endtask

  // Register writes happen only with the parser closed and nothing in flight,
  // so the copy of the target is updated as the write is issued.
  task automatic write_reg(input logic [fdns_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [fdns_pkg::CFG_DATA_W-1:0] value);
    int w;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == fdns_pkg::REG_NAME_LENGTH) begin
      target_len = value[fdns_pkg::LEN_W-1:0];
    end else begin
      w = idx - fdns_pkg::REG_NAME_WORD_0;
      for (int j = 0; j < 8; j++) target_name[8*w+j] = value[8*j +: 8];
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // The input item is held until taken; a new one is offered only after the
  // previous one was accepted or when nothing is being offered.
  always @(negedge clk) begin
    if (!s_tvalid || in_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser  <= byte_queue[0].first;
        s_tdata  <= byte_queue[0].data;
        void'(byte_queue.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Accepted input items feed the search prediction; accepted results are
  // checked against the oldest owed result.
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) search_byte(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result with none owed: found=%0b key=%h size=%h",
                     m_tuser, m_tdata[15:0], m_tdata[47:16]);
          end
        end else begin
          if (m_tuser !== results_due[0].found ||
              m_tdata[15:0] !== results_due[0].entry_key ||
              m_tdata[47:16] !== results_due[0].entry_size) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display({"result mismatch: expected found=%0b key=%h size=%h,",
                        " got found=%0b key=%h size=%h"},
                       results_due[0].found, results_due[0].entry_key,
                       results_due[0].entry_size, m_tuser, m_tdata[15:0],
                       m_tdata[47:16]);
            end
          end
          void'(results_due.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  // Nine phases, each with its own target: three with a slow sender, three
  // with a slow receiver, three at full rate. Each phase writes every register,
  // sends its directories and waits until the block has gone quiet.
  initial begin
    int          len;
    int          sel;
    int          c;
    int          m;
    logic [63:0] w;
    foreach (target_name[j]) target_name[j] = 8'h00;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      // Target lengths cover the empty name, the longest name that fits, a
      // name that leaves no room for its zero byte and the register maximum.
      case (p)
        0:       len = 5;
        1:       len = 0;
        2:       len = fdns_pkg::NAME_MAX - 1;
        3:       len = fdns_pkg::NAME_MAX;
        5:       len = (1 << fdns_pkg::LEN_W) - 1;
        6:       len = 8;
        8:       len = fdns_pkg::NAME_MAX - 1;
        default: len = $urandom_range(1, fdns_pkg::NAME_MAX - 2);
      endcase
      write_reg(fdns_pkg::REG_NAME_LENGTH, fdns_pkg::CFG_DATA_W'(len));
      for (int k = 0; k < fdns_pkg::NAME_WORDS; k++) begin
        w = (p == 1) ? '0 : (p == 2) ? '1 : {$urandom, $urandom};
        write_reg(fdns_pkg::REG_NAME_WORD_0 + fdns_pkg::CFG_IDX_W'(k), w);
      end
      @(negedge clk);
      cfg_we <= 1'b0;

      gen_items = 0;
      gen_dirs  = 0;
      if (p == 0) begin
        push_noise(3, 0);                        // bytes with no directory open
        add_directory(32'h0, 0, -1, -1);         // empty directory
        add_directory(32'h1, 0, -1, 2);          // restart inside the count
        add_directory(32'h1, 1, 0, -1);          // single entry that matches
        push_noise(2, 0);                        // ignored after the result
        add_directory(32'h2, 2, -1, -1);         // two entries, no match
        add_directory(32'hFFFF_FFFF, 2, 1, -1);  // huge count, second entry matches
        add_directory(32'h1, 1, -1, 40);         // restart inside an entry
        add_directory(32'h3, 3, -1, -1);
      end

      // Mostly well-formed directories with random content; the rest are
      // truncated directories and loose bytes.
      while (gen_items < 100 || gen_dirs < 1) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          add_directory(32'h0, 0, -1, -1);
        end else if (sel < 68) begin
          c = $urandom_range(1, 3);
          m = $urandom_range(0, 2 * c - 1);
          add_directory(c, (m < c) ? m + 1 : c, m, -1);
        end else if (sel < 76) begin
          m = $urandom_range(0, 1);
          add_directory({8'($urandom_range(1, 255)), 24'($urandom)}, m + 1, m, -1);
        end else if (sel < 90) begin
          c = $urandom_range(1, 3);
          add_directory(c, c, -1,
                        $urandom_range(1, fdns_pkg::COUNT_BYTES + c * ENTRY_LEN - 1));
        end else begin
          push_noise($urandom_range(1, 12), 12);
        end
        if ($urandom_range(0, 3) == 0) push_noise($urandom_range(1, 4), 0);
      end
      // An empty directory closes whatever is still open before the next writes.
      add_directory(32'h0, 0, -1, -1);

      while (byte_queue.size() != 0 || s_tvalid || results_due.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fdns_pkg.sv
rtl/fdns_core.sv
rtl/file_directory_name_search.sv
rtl/fdns_checker.sv
dv/file_directory_name_search_tb.sv
